// ===== rtl/core/reorder_buffer_in_order_release_assert.svh =====
// Assertion macros shared by the reorder buffer RTL.
`ifndef REORDER_BUFFER_IN_ORDER_RELEASE_ASSERT_SVH
`define REORDER_BUFFER_IN_ORDER_RELEASE_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define ROB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ROB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rob_pkg.sv =====
// Package with types, codes and defaults of the in-order release reorder buffer.
package rob_pkg;

	localparam int ID_W         = 16;
	localparam int MSG_HANDLE_W = 16;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 2;

	localparam int SLOT_COUNT_DEF   = 32;
	localparam int HANDLE_WIDTH_DEF = 16;

	// Register reset values
	localparam logic [CFG_W-1:0] START_ID_RST     = 16'd0;
	localparam logic [CFG_W-1:0] MAX_DISTANCE_RST = 16'd16;
	localparam logic [CFG_W-1:0] DISC_LIMIT_RST   = 16'd100;
	localparam logic [CFG_W-1:0] MAX_SEQ_ID_RST   = 16'hFFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_ID,
		CFG_MAX_DISTANCE,
		CFG_DISCARD_LIMIT,
		CFG_MAX_SEQ_ID
	} rob_cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_ACCEPTED,
		STAT_DUPLICATE,
		STAT_DROPPED,
		STAT_LIMIT
	} rob_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_READ,
		S_EMIT
	} rob_state_t;

	typedef struct packed {
		logic [CFG_W-1:0] init_id;
		logic [CFG_W-1:0] max_distance;
		logic [CFG_W-1:0] discard_limit;
		logic [CFG_W-1:0] max_sequence_id;
	} rob_cfg_t;

endpackage

// ===== rtl/core/rob_in_if.sv =====
// Arrival channel: sequence id and handle of one incoming message.
interface rob_in_if;
	logic                            valid;
	logic                            ready;
	logic [rob_pkg::ID_W-1:0]        message_id;
	logic [rob_pkg::MSG_HANDLE_W-1:0] message_handle;

	modport source(output valid, output message_id, output message_handle, input ready);
	modport sink(input valid, input message_id, input message_handle, output ready);
endinterface

// ===== rtl/core/rob_out_if.sv =====
// Result channel: released messages and per-arrival status.
interface rob_out_if;
	logic                             valid;
	logic                             ready;
	logic                             has_message;
	logic [rob_pkg::MSG_HANDLE_W-1:0] out_handle;
	logic [rob_pkg::ID_W-1:0]         out_id;
	logic [1:0]                       status;
	logic                             last;

	modport source(output valid, output has_message, output out_handle, output out_id,
		output status, output last, input ready);
	modport sink(input valid, input has_message, input out_handle, input out_id,
		input status, input last, output ready);
endinterface

// ===== rtl/core/reorder_buffer_in_order_release.sv =====
// Top level of the in-order release reorder buffer with its slot handle memory.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------------
//  arrival  | in  | valid / ready    | message_id, message_handle
//  result   | out | valid / ready    | has_message, out_handle, out_id, status, last
//  cfg      | in  | cfg_we           | cfg_index, cfg_data
//
// An arrival that yields one result passes through accept, then decide.
// An in-order arrival releases its run one message at a time: each handle is read
// from the handle memory into a read register ahead of the output register.
// Reset clears the slot valid bits at once; the handle memory needs no clearing.
// A stalled result holds the block in place; new arrivals wait until it is idle.
`include "reorder_buffer_in_order_release_assert.svh"

module reorder_buffer_in_order_release #(
	parameter int SLOT_COUNT   = rob_pkg::SLOT_COUNT_DEF,
	parameter int HANDLE_WIDTH = rob_pkg::HANDLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rob_in_if.sink                         arrival,
	rob_out_if.source                      result,
	input  logic                           cfg_we,
	input  logic [rob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rob_pkg::CFG_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	rob_pkg::rob_state_t state_q, state_d;
	rob_pkg::rob_cfg_t   cfg_q;

	logic [rob_pkg::ID_W-1:0]  expected_id_q;
	logic [rob_pkg::CFG_W-1:0] discard_count_q;
	logic [SLOT_COUNT-1:0]     slot_valid_q;
	logic [IDX_W-1:0]          walk_idx_q;
	logic [IDX_W-1:0]          count_q;

	logic [rob_pkg::ID_W-1:0]  id_s1;
	logic [HANDLE_WIDTH-1:0]   handle_s1;

	logic [HANDLE_WIDTH-1:0]   slot_mem [SLOT_COUNT];
	logic [HANDLE_WIDTH-1:0]   mem_rdata_q;

	logic                      out_valid_q;
	logic                      out_has_q;
	logic [rob_pkg::MSG_HANDLE_W-1:0] out_handle_q;
	logic [rob_pkg::ID_W-1:0]  out_id_q;
	rob_pkg::rob_status_t      out_status_q;
	logic                      out_last_q;

	logic                      take;
	logic                      drop;
	logic                      is_expected;
	logic                      out_free;
	logic                      single_fire;
	logic                      emit_fire;
	logic                      mem_we;
	logic                      mem_re;
	logic [IDX_W-1:0]          in_idx;
	logic [IDX_W-1:0]          walk_next;
	logic [rob_pkg::CFG_W-1:0] disc_next;
	logic                      limit_hit;
	logic                      emit_last;
	rob_pkg::rob_status_t      single_status;

	rob_window_check u_window (
		.cfg         (cfg_q),
		.expected_id (expected_id_q),
		.message_id  (id_s1),
		.drop        (drop)
	);

	// Slot index, walk step, discard counter update, limit and release checks
	always_comb begin
		in_idx      = id_s1[IDX_W-1:0] & IDX_LAST;
		walk_next   = (walk_idx_q == IDX_LAST) ? '0 : walk_idx_q + 1'b1;
		disc_next   = (discard_count_q == '1) ? discard_count_q : discard_count_q + 1'b1;
		limit_hit   = disc_next >= cfg_q.discard_limit;
		is_expected = !drop && (id_s1 == expected_id_q);
		emit_last   = !slot_valid_q[walk_next] || (count_q == IDX_LAST);
		out_free    = !out_valid_q || result.ready;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rob_pkg::S_IDLE:   if (arrival.valid) state_d = rob_pkg::S_DECIDE;
			rob_pkg::S_DECIDE: begin
				if (is_expected) state_d = rob_pkg::S_READ;
				else if (out_free) state_d = rob_pkg::S_IDLE;
			end
			rob_pkg::S_READ:   state_d = rob_pkg::S_EMIT;
			rob_pkg::S_EMIT: begin
				if (out_free) state_d = emit_last ? rob_pkg::S_IDLE : rob_pkg::S_READ;
			end
			default:           state_d = rob_pkg::S_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		take        = (state_q == rob_pkg::S_IDLE);
		single_fire = (state_q == rob_pkg::S_DECIDE) && !is_expected && out_free;
		mem_we      = (state_q == rob_pkg::S_DECIDE) &&
			(is_expected || (single_fire && !drop && !slot_valid_q[in_idx]));
		mem_re      = (state_q == rob_pkg::S_READ);
		emit_fire   = (state_q == rob_pkg::S_EMIT) && out_free;
		if (drop) single_status = limit_hit ? rob_pkg::STAT_LIMIT : rob_pkg::STAT_DROPPED;
		else if (slot_valid_q[in_idx]) single_status = rob_pkg::STAT_DUPLICATE;
		else single_status = rob_pkg::STAT_ACCEPTED;
	end

	assign arrival.ready      = take;
	assign result.valid       = out_valid_q;
	assign result.has_message = out_has_q;
	assign result.out_handle  = out_handle_q;
	assign result.out_id      = out_id_q;
	assign result.status      = out_status_q;
	assign result.last        = out_last_q;

	// Control state, registers and slot bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= rob_pkg::S_IDLE;
			cfg_q.init_id         <= rob_pkg::START_ID_RST;
			cfg_q.max_distance    <= rob_pkg::MAX_DISTANCE_RST;
			cfg_q.discard_limit   <= rob_pkg::DISC_LIMIT_RST;
			cfg_q.max_sequence_id <= rob_pkg::MAX_SEQ_ID_RST;
			expected_id_q   <= rob_pkg::START_ID_RST;
			discard_count_q <= '0;
			slot_valid_q    <= '0;
			walk_idx_q      <= '0;
			count_q         <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (rob_pkg::rob_cfg_idx_t'(cfg_index))
					rob_pkg::CFG_START_ID: begin
						cfg_q.init_id <= cfg_data;
						expected_id_q <= cfg_data;
					end
					rob_pkg::CFG_MAX_DISTANCE:  cfg_q.max_distance    <= cfg_data;
					rob_pkg::CFG_DISCARD_LIMIT: cfg_q.discard_limit   <= cfg_data;
					rob_pkg::CFG_MAX_SEQ_ID:    cfg_q.max_sequence_id <= cfg_data;
					default: ;
				endcase
			end
			if (single_fire && drop) discard_count_q <= disc_next;
			if (mem_we) slot_valid_q[in_idx] <= 1'b1;
			if ((state_q == rob_pkg::S_DECIDE) && is_expected) begin
				walk_idx_q <= in_idx;
				count_q    <= '0;
			end
			// Advance the release walk
			if (emit_fire) begin
				slot_valid_q[walk_idx_q] <= 1'b0;
				walk_idx_q    <= walk_next;
				count_q       <= count_q + 1'b1;
				expected_id_q <= expected_id_q + 1'b1;
			end
			if (single_fire || emit_fire) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// Capture the accepted request
	always_ff @(posedge clk) begin
		if (take && arrival.valid) begin
			id_s1     <= arrival.message_id;
			handle_s1 <= HANDLE_WIDTH'(arrival.message_handle);
		end
	end

	// Slot handle memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) slot_mem[in_idx] <= handle_s1;
		if (mem_re) mem_rdata_q <= slot_mem[walk_idx_q];
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (single_fire) begin
			out_has_q    <= 1'b0;
			out_handle_q <= '0;
			out_id_q     <= '0;
			out_status_q <= single_status;
			out_last_q   <= 1'b1;
		end else if (emit_fire) begin
			out_has_q    <= 1'b1;
			out_handle_q <= rob_pkg::MSG_HANDLE_W'(mem_rdata_q);
			out_id_q     <= expected_id_q;
			out_status_q <= rob_pkg::STAT_ACCEPTED;
			out_last_q   <= emit_last;
		end
	end

	// The walk only reads slots that hold a message
	`ROB_ASSERT_SAME(a_walk_slot_valid, clk, arst_n, state_q == rob_pkg::S_READ, slot_valid_q[walk_idx_q], "release walk read an empty slot")
	// Each released message moves the expected id on by one
	`ROB_ASSERT_NEXT(a_expected_step, clk, arst_n, emit_fire, expected_id_q == rob_pkg::ID_W'($past(expected_id_q) + 1'b1), "expected id did not advance on release")
	// A result without a message is the only result of its arrival
	`ROB_ASSERT_SAME(a_single_last, clk, arst_n, result.valid && !result.has_message, result.last, "single result not marked last")

endmodule

// ===== rtl/core/rob_window_check.sv =====
// Receive window test: distance to the expected id and wrap guard near the top id.
module rob_window_check (
	input  rob_pkg::rob_cfg_t        cfg,
	input  logic [rob_pkg::ID_W-1:0] expected_id,
	input  logic [rob_pkg::ID_W-1:0] message_id,
	output logic                     drop
);

	logic signed [rob_pkg::ID_W:0]   id_delta;
	logic        [rob_pkg::ID_W:0]   delta_abs;
	logic        [rob_pkg::ID_W-1:0] half;
	logic signed [rob_pkg::ID_W+1:0] wrap_floor;
	logic                            too_far;
	logic                            near_top;

	// Absolute signed distance against the window size
	always_comb begin
		id_delta  = $signed({1'b0, message_id}) - $signed({1'b0, expected_id});
		delta_abs = id_delta[rob_pkg::ID_W] ? (rob_pkg::ID_W+1)'(-id_delta)
			: (rob_pkg::ID_W+1)'(id_delta);
		too_far   = delta_abs > {1'b0, cfg.max_distance};
	end

	// Expected id close to the top while the new id already wrapped low
	always_comb begin
		half       = cfg.max_distance >> 1;
		wrap_floor = $signed({2'b00, cfg.max_sequence_id}) - $signed({2'b00, half});
		near_top   = $signed({2'b00, expected_id}) > wrap_floor;
		drop       = too_far || (near_top && (message_id < half));
	end

endmodule
